FILE: src/pict_pkg.sv
// shared types, constants and step table for the periodic image counter tracker
package pict_pkg;

  localparam int ATOM_W     = 12;
  localparam int ATOMS      = 4096;
  localparam int POS_W      = 32;
  localparam int DIFF_W     = POS_W + 1;
  localparam int CNT_W      = 32;
  localparam int BOX_W      = 31;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ACC_W      = 66;
  localparam int DVD_W      = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_YX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_YY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_ZX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_ZY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_ZZ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd6;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOLAT = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  typedef enum logic [1:0] {KIND_SET, KIND_ADD, KIND_READ} kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [ATOM_W-1:0]        atom;
    logic signed [POS_W-1:0]  ref_x;
    logic signed [POS_W-1:0]  ref_y;
    logic signed [POS_W-1:0]  ref_z;
    logic signed [POS_W-1:0]  cur_x;
    logic signed [POS_W-1:0]  cur_y;
    logic signed [POS_W-1:0]  cur_z;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [1:0] {OP_DIV, OP_MAC, OP_CMP} op_kind_e;
  typedef enum logic [2:0] {BOX_XX, BOX_YX, BOX_YY, BOX_ZX, BOX_ZY, BOX_ZZ} box_e;
  typedef enum logic [3:0] {
    BASE_ACC, BASE_DX, BASE_DY, BASE_DZ, BASE_BX, BASE_BY, BASE_BZ,
    BASE_AX, BASE_AY, BASE_AZ
  } base_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [1:0] lane;
    box_e       box;
    base_e      base;
    logic       sub;
  } uop_t;

  typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_ACC, ST_DIV, ST_DONE} back_state_e;

  localparam logic [3:0] LAST_STEP = 4'd14;

  // solve z, y, x then rebuild and compare each coordinate
  function automatic uop_t step_op(logic [3:0] step);
    uop_t op;
    case (step)
      4'd0:    op = '{OP_DIV, 2'd2, BOX_ZZ, BASE_DZ,  1'b0};
      4'd1:    op = '{OP_MAC, 2'd2, BOX_ZY, BASE_DY,  1'b1};
      4'd2:    op = '{OP_DIV, 2'd1, BOX_YY, BASE_ACC, 1'b0};
      4'd3:    op = '{OP_MAC, 2'd1, BOX_YX, BASE_DX,  1'b1};
      4'd4:    op = '{OP_MAC, 2'd2, BOX_ZX, BASE_ACC, 1'b1};
      4'd5:    op = '{OP_DIV, 2'd0, BOX_XX, BASE_ACC, 1'b0};
      4'd6:    op = '{OP_MAC, 2'd0, BOX_XX, BASE_BX,  1'b0};
      4'd7:    op = '{OP_MAC, 2'd1, BOX_YX, BASE_ACC, 1'b0};
      4'd8:    op = '{OP_MAC, 2'd2, BOX_ZX, BASE_ACC, 1'b0};
      4'd9:    op = '{OP_CMP, 2'd0, BOX_XX, BASE_AX,  1'b0};
      4'd10:   op = '{OP_MAC, 2'd1, BOX_YY, BASE_BY,  1'b0};
      4'd11:   op = '{OP_MAC, 2'd2, BOX_ZY, BASE_ACC, 1'b0};
      4'd12:   op = '{OP_CMP, 2'd0, BOX_XX, BASE_AY,  1'b0};
      4'd13:   op = '{OP_MAC, 2'd2, BOX_ZZ, BASE_BZ,  1'b0};
      default: op = '{OP_CMP, 2'd0, BOX_XX, BASE_AZ,  1'b0};
    endcase
    return op;
  endfunction

endpackage

FILE: src/pict_front.sv
// front part: accepts items, classifies the command, forms differences, two-entry queue
module pict_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [pict_pkg::ATOM_W-1:0]         atom_i,
  input  logic signed [pict_pkg::POS_W-1:0]   ref_x_i,
  input  logic signed [pict_pkg::POS_W-1:0]   ref_y_i,
  input  logic signed [pict_pkg::POS_W-1:0]   ref_z_i,
  input  logic signed [pict_pkg::POS_W-1:0]   cur_x_i,
  input  logic signed [pict_pkg::POS_W-1:0]   cur_y_i,
  input  logic signed [pict_pkg::POS_W-1:0]   cur_z_i,
  output pict_pkg::head_t                     head_o,
  input  logic                                pop_i
);

  pict_pkg::item_t entry_q [2];
  pict_pkg::item_t new_item;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            push;

  always_comb begin
    new_item.atom  = atom_i;
    new_item.ref_x = ref_x_i;
    new_item.ref_y = ref_y_i;
    new_item.ref_z = ref_z_i;
    new_item.cur_x = cur_x_i;
    new_item.cur_y = cur_y_i;
    new_item.cur_z = cur_z_i;
    new_item.dx    = {ref_x_i[pict_pkg::POS_W-1], ref_x_i} - {cur_x_i[pict_pkg::POS_W-1], cur_x_i};
    new_item.dy    = {ref_y_i[pict_pkg::POS_W-1], ref_y_i} - {cur_y_i[pict_pkg::POS_W-1], cur_y_i};
    new_item.dz    = {ref_z_i[pict_pkg::POS_W-1], ref_z_i} - {cur_z_i[pict_pkg::POS_W-1], cur_z_i};
    unique case (command_i)
      pict_pkg::CMD_SET: new_item.kind = pict_pkg::KIND_SET;
      pict_pkg::CMD_ADD: new_item.kind = pict_pkg::KIND_ADD;
      default:           new_item.kind = pict_pkg::KIND_READ;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= new_item;
  end

endmodule

FILE: src/pict_div.sv
// shared restoring divider: magnitude over a diagonal, rounded half away from zero
module pict_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pict_pkg::DVD_W-1:0]   dividend_i,
  input  logic [pict_pkg::BOX_W-1:0]          divisor_i,
  output logic                                done_o,
  output logic signed [pict_pkg::CNT_W-1:0]   quot_o,
  output logic                                ovf_o
);

  localparam int CW = $clog2(pict_pkg::DVD_W);

  logic                           busy_q, done_q, neg_q;
  logic [CW-1:0]                  cnt_q;
  logic [pict_pkg::BOX_W-1:0]     rem_q, d_q;
  logic [pict_pkg::DVD_W-1:0]     quo_q;
  logic [pict_pkg::BOX_W:0]       trial;
  logic                           ge;
  logic [pict_pkg::BOX_W:0]       diff;
  logic                           round_up;
  logic [pict_pkg::DVD_W:0]       q1;
  logic [pict_pkg::DVD_W:0]       lim;

  assign trial    = {rem_q, quo_q[pict_pkg::DVD_W-1]};
  assign ge       = trial >= {1'b0, d_q};
  assign diff     = trial - {1'b0, d_q};
  assign round_up = {rem_q, 1'b0} >= {1'b0, d_q};
  assign q1       = {1'b0, quo_q} + {{pict_pkg::DVD_W{1'b0}}, round_up};
  // negative side reaches one further
  assign lim      = {{(pict_pkg::DVD_W-pict_pkg::CNT_W+1){1'b0}}, 1'b1,
                     {(pict_pkg::CNT_W-1){1'b0}}} - {{pict_pkg::DVD_W{1'b0}}, ~neg_q};
  assign ovf_o    = q1 > lim;
  assign quot_o   = neg_q ? -q1[pict_pkg::CNT_W-1:0] : q1[pict_pkg::CNT_W-1:0];
  assign done_o   = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(pict_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[pict_pkg::DVD_W-1];
      quo_q <= dividend_i[pict_pkg::DVD_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[pict_pkg::BOX_W-1:0] : trial[pict_pkg::BOX_W-1:0];
      quo_q <= {quo_q[pict_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

FILE: src/pict_back.sv
// back part: step sequencer, multiplier, counter table and result register
module pict_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pict_pkg::head_t                     head_i,
  output logic                                pop_o,
  input  logic                                cfg_we_i,
  input  logic [pict_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pict_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pict_pkg::ATOM_W-1:0]         atom_out_o,
  output logic signed [pict_pkg::CNT_W-1:0]   count_x_o,
  output logic signed [pict_pkg::CNT_W-1:0]   count_y_o,
  output logic signed [pict_pkg::CNT_W-1:0]   count_z_o,
  output logic [1:0]                          status_o
);

  localparam int AW = pict_pkg::ACC_W;
  localparam int CW = pict_pkg::CNT_W;

  logic [pict_pkg::BOX_W-1:0]  box_xx_q, box_yy_q, box_zz_q;
  logic signed [CW-1:0]        box_yx_q, box_zx_q, box_zy_q;
  logic [pict_pkg::TOL_W-1:0]  tol_q;

  pict_pkg::back_state_e       state_q, state_d;
  pict_pkg::item_t             it_q;
  logic [3:0]                  step_q;
  logic                        fail_q;
  logic signed [AW-1:0]        acc_q, acc_next, base_val, err;
  logic signed [2*CW-1:0]      prod_q;
  logic signed [CW-1:0]        n_q [3];
  logic signed [CW-1:0]        mul_a, box_val;
  pict_pkg::uop_t              op;

  logic [3*CW-1:0]             mem [pict_pkg::ATOMS];
  logic [3*CW-1:0]             rd_q;
  logic signed [CW-1:0]        rd_c [3];
  logic signed [CW:0]          sum [3];
  logic                        sum_ovf;
  logic signed [CW-1:0]        res [3];
  logic [1:0]                  res_status;

  logic pop, div_start, mac_en, acc_en, n_en, step_inc, fail_set, out_load, mem_we;
  logic diag_zero, acc_bad, cmp_ok;
  logic div_done, div_ovf;
  logic signed [CW-1:0] div_quot;

  logic out_valid_q;
  logic [pict_pkg::ATOM_W-1:0] atom_out_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [1:0] status_q;

  assign op        = pict_pkg::step_op(step_q);
  assign diag_zero = (box_xx_q == '0) || (box_yy_q == '0) || (box_zz_q == '0);
  assign mul_a     = n_q[op.lane];

  always_comb begin
    case (op.box)
      pict_pkg::BOX_XX: box_val = {1'b0, box_xx_q};
      pict_pkg::BOX_YX: box_val = box_yx_q;
      pict_pkg::BOX_YY: box_val = {1'b0, box_yy_q};
      pict_pkg::BOX_ZX: box_val = box_zx_q;
      pict_pkg::BOX_ZY: box_val = box_zy_q;
      default:          box_val = {1'b0, box_zz_q};
    endcase
    case (op.base)
      pict_pkg::BASE_ACC: base_val = acc_q;
      pict_pkg::BASE_DX:  base_val = {{(AW-pict_pkg::DIFF_W){it_q.dx[pict_pkg::DIFF_W-1]}}, it_q.dx};
      pict_pkg::BASE_DY:  base_val = {{(AW-pict_pkg::DIFF_W){it_q.dy[pict_pkg::DIFF_W-1]}}, it_q.dy};
      pict_pkg::BASE_DZ:  base_val = {{(AW-pict_pkg::DIFF_W){it_q.dz[pict_pkg::DIFF_W-1]}}, it_q.dz};
      pict_pkg::BASE_BX:  base_val = {{(AW-pict_pkg::POS_W){it_q.cur_x[pict_pkg::POS_W-1]}}, it_q.cur_x};
      pict_pkg::BASE_BY:  base_val = {{(AW-pict_pkg::POS_W){it_q.cur_y[pict_pkg::POS_W-1]}}, it_q.cur_y};
      pict_pkg::BASE_BZ:  base_val = {{(AW-pict_pkg::POS_W){it_q.cur_z[pict_pkg::POS_W-1]}}, it_q.cur_z};
      pict_pkg::BASE_AX:  base_val = {{(AW-pict_pkg::POS_W){it_q.ref_x[pict_pkg::POS_W-1]}}, it_q.ref_x};
      pict_pkg::BASE_AY:  base_val = {{(AW-pict_pkg::POS_W){it_q.ref_y[pict_pkg::POS_W-1]}}, it_q.ref_y};
      default:            base_val = {{(AW-pict_pkg::POS_W){it_q.ref_z[pict_pkg::POS_W-1]}}, it_q.ref_z};
    endcase
  end

  // partial sums must stay inside the signed 64-bit range
  assign acc_next = op.sub ? base_val - {{(AW-2*CW){prod_q[2*CW-1]}}, prod_q}
                           : base_val + {{(AW-2*CW){prod_q[2*CW-1]}}, prod_q};
  assign acc_bad  = !((acc_next[AW-1:2*CW-1] == '0) || (acc_next[AW-1:2*CW-1] == '1));
  assign err      = acc_q - base_val;
  assign cmp_ok   = (err <= $signed({{(AW-pict_pkg::TOL_W){1'b0}}, tol_q})) &&
                    (err >= -$signed({{(AW-pict_pkg::TOL_W){1'b0}}, tol_q}));

  pict_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (base_val[pict_pkg::DVD_W-1:0]),
    .divisor_i  (box_val[pict_pkg::BOX_W-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .ovf_o      (div_ovf)
  );

  always_comb begin
    sum_ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rd_c[i] = rd_q[i*CW +: CW];
      sum[i]  = {rd_c[i][CW-1], rd_c[i]} + {n_q[i][CW-1], n_q[i]};
      if (sum[i][CW] != sum[i][CW-1]) sum_ovf = 1'b1;
    end
    res_status = pict_pkg::STATUS_OK;
    for (int i = 0; i < 3; i++) begin
      if (fail_q) res[i] = '0;
      else begin
        case (it_q.kind)
          pict_pkg::KIND_SET: res[i] = n_q[i];
          pict_pkg::KIND_ADD: res[i] = sum_ovf ? rd_c[i] : sum[i][CW-1:0];
          default:            res[i] = rd_c[i];
        endcase
      end
    end
    if (fail_q) res_status = pict_pkg::STATUS_NOLAT;
    else if (it_q.kind == pict_pkg::KIND_ADD && sum_ovf) res_status = pict_pkg::STATUS_OVF;
  end

  always_comb begin
    state_d   = state_q;
    pop       = 1'b0;
    div_start = 1'b0;
    mac_en    = 1'b0;
    acc_en    = 1'b0;
    n_en      = 1'b0;
    step_inc  = 1'b0;
    fail_set  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    unique case (state_q)
      pict_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop = 1'b1;
          if (head_i.item.kind == pict_pkg::KIND_READ || diag_zero) state_d = pict_pkg::ST_DONE;
          else state_d = pict_pkg::ST_ISSUE;
        end
      end
      pict_pkg::ST_ISSUE: begin
        unique case (op.kind)
          pict_pkg::OP_DIV: begin
            div_start = 1'b1;
            state_d   = pict_pkg::ST_DIV;
          end
          pict_pkg::OP_MAC: begin
            mac_en  = 1'b1;
            state_d = pict_pkg::ST_ACC;
          end
          default: begin
            if (!cmp_ok) begin
              fail_set = 1'b1;
              state_d  = pict_pkg::ST_DONE;
            end else if (step_q == pict_pkg::LAST_STEP) begin
              state_d = pict_pkg::ST_DONE;
            end else begin
              step_inc = 1'b1;
            end
          end
        endcase
      end
      pict_pkg::ST_ACC: begin
        acc_en = 1'b1;
        if (acc_bad) begin
          fail_set = 1'b1;
          state_d  = pict_pkg::ST_DONE;
        end else begin
          step_inc = 1'b1;
          state_d  = pict_pkg::ST_ISSUE;
        end
      end
      pict_pkg::ST_DIV: begin
        if (div_done) begin
          n_en = 1'b1;
          if (div_ovf) begin
            fail_set = 1'b1;
            state_d  = pict_pkg::ST_DONE;
          end else begin
            step_inc = 1'b1;
            state_d  = pict_pkg::ST_ISSUE;
          end
        end
      end
      pict_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          mem_we   = !fail_q && ((it_q.kind == pict_pkg::KIND_SET) ||
                                 (it_q.kind == pict_pkg::KIND_ADD && !sum_ovf));
          state_d  = pict_pkg::ST_IDLE;
        end
      end
      default: state_d = pict_pkg::ST_IDLE;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pict_pkg::ST_IDLE;
      step_q      <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
      box_xx_q    <= 31'd65536;
      box_yx_q    <= '0;
      box_yy_q    <= 31'd65536;
      box_zx_q    <= '0;
      box_zy_q    <= '0;
      box_zz_q    <= 31'd65536;
      tol_q       <= 16'd1;
    end else begin
      state_q <= state_d;
      if (pop) begin
        step_q <= '0;
        fail_q <= (head_i.item.kind != pict_pkg::KIND_READ) && diag_zero;
      end else begin
        if (step_inc) step_q <= step_q + 4'd1;
        if (fail_set) fail_q <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pict_pkg::CFG_BOX_XX: box_xx_q <= cfg_data_i[pict_pkg::BOX_W-1:0];
          pict_pkg::CFG_BOX_YX: box_yx_q <= cfg_data_i;
          pict_pkg::CFG_BOX_YY: box_yy_q <= cfg_data_i[pict_pkg::BOX_W-1:0];
          pict_pkg::CFG_BOX_ZX: box_zx_q <= cfg_data_i;
          pict_pkg::CFG_BOX_ZY: box_zy_q <= cfg_data_i;
          pict_pkg::CFG_BOX_ZZ: box_zz_q <= cfg_data_i[pict_pkg::BOX_W-1:0];
          pict_pkg::CFG_TOL:    tol_q    <= cfg_data_i[pict_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) it_q <= head_i.item;
    if (mac_en) prod_q <= mul_a * box_val;
    if (acc_en) acc_q <= acc_next;
    if (n_en) n_q[op.lane] <= div_quot;
    if (out_load) begin
      atom_out_q <= it_q.atom;
      cx_q       <= res[0];
      cy_q       <= res[1];
      cz_q       <= res[2];
      status_q   <= res_status;
    end
  end

  // counter table, one read at dequeue and one write at commit
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[it_q.atom] <= {res[2], res[1], res[0]};
    if (pop) rd_q <= mem[head_i.item.atom];
  end

  assign out_valid_o = out_valid_q;
  assign atom_out_o  = atom_out_q;
  assign count_x_o   = cx_q;
  assign count_y_o   = cy_q;
  assign count_z_o   = cz_q;
  assign status_o    = status_q;

endmodule

FILE: src/periodic_image_counter_tracker.sv
// Per-atom periodic image counter tracker for a lower-triangular box.
// Input channel (in_valid_i/in_ready_o): command, atom and two Q16.16 positions.
// Output channel (out_valid_o/out_ready_i): atom, three image counters, status.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
// write only while no item is in flight.
// A two-entry queue decouples intake from execution, so up to two items are
// taken while the back end is busy or the receiver stalls.
// Set and add solve z, y, x with a shared 64-step restoring divider, then
// rebuild and compare through one 32x32 multiplier and a 66-bit adder;
// the three divisions take most of the time of a full solve.
// A read, or a box with a zero diagonal, goes straight to the commit step.
// One result per item, in order; a stalled output holds its result while the
// back end waits in its commit step.
// Reset clears control, sets box diagonals to 1.0 and the tolerance to 1;
// the counter table is not cleared, so an atom must be set before it is added
// to or read.
module periodic_image_counter_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [pict_pkg::ATOM_W-1:0]         atom_i,
  input  logic signed [pict_pkg::POS_W-1:0]   ref_x_i,
  input  logic signed [pict_pkg::POS_W-1:0]   ref_y_i,
  input  logic signed [pict_pkg::POS_W-1:0]   ref_z_i,
  input  logic signed [pict_pkg::POS_W-1:0]   cur_x_i,
  input  logic signed [pict_pkg::POS_W-1:0]   cur_y_i,
  input  logic signed [pict_pkg::POS_W-1:0]   cur_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pict_pkg::ATOM_W-1:0]         atom_out_o,
  output logic signed [pict_pkg::CNT_W-1:0]   count_x_o,
  output logic signed [pict_pkg::CNT_W-1:0]   count_y_o,
  output logic signed [pict_pkg::CNT_W-1:0]   count_z_o,
  output logic [1:0]                          status_o,
  input  logic                                cfg_we_i,
  input  logic [pict_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pict_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  pict_pkg::head_t head;
  logic            pop;

  pict_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .atom_i     (atom_i),
    .ref_x_i    (ref_x_i),
    .ref_y_i    (ref_y_i),
    .ref_z_i    (ref_z_i),
    .cur_x_i    (cur_x_i),
    .cur_y_i    (cur_y_i),
    .cur_z_i    (cur_z_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  pict_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .atom_out_o  (atom_out_o),
    .count_x_o   (count_x_o),
    .count_y_o   (count_y_o),
    .count_z_o   (count_z_o),
    .status_o    (status_o)
  );

endmodule
